[rtl/core/lgcp_pkg.sv]
// Shared constants and types for the largest-gap channel picker.
package lgcp_pkg;

  localparam int NUM_CHANNELS = 8192;
  localparam int CHAN_W       = $clog2(NUM_CHANNELS);
  localparam int WORD_W       = 32;
  localparam int BIT_W        = $clog2(WORD_W);
  localparam int MAP_WORDS    = NUM_CHANNELS / WORD_W;
  localparam int ADDR_W       = $clog2(MAP_WORDS);
  localparam int RND_W        = 16;
  localparam int HALF_W       = CHAN_W - 1;
  localparam int GAP_WIDE_LIMIT = 4;
  localparam int GAP_MIN_LIMIT  = 1;

  localparam logic [1:0] CMD_RESTART  = 2'd0;
  localparam logic [1:0] CMD_RECENTRE = 2'd1;
  localparam logic [1:0] CMD_BISECT   = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic              clear;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

endpackage

[rtl/core/lgcp_map_ram.sv]
// Probed-channel bitmap memory with per-word valid bits.
module lgcp_map_ram
  import lgcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ram_req_t          req,
  output logic [WORD_W-1:0] rdata,
  output logic              rvalid
);

  logic [WORD_W-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] word_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

  // a word that is not valid reads back with rvalid low
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      word_valid <= '0;
      rvalid     <= 1'b0;
    end else begin
      if (req.wr_en) begin
        word_valid[req.addr] <= 1'b1;
      end
      rvalid <= word_valid[req.addr];
    end
  end

endmodule

[rtl/core/lgcp_mod_unit.sv]
// Restoring remainder unit, one dividend bit per cycle.
module lgcp_mod_unit
  import lgcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RND_W-1:0]  dividend,
  input  logic [HALF_W-1:0] divisor,
  output logic              done,
  output logic [HALF_W-1:0] rem
);

  localparam int CNT_W = $clog2(RND_W + 1);

  logic [RND_W-1:0]  dvd;
  logic [HALF_W-1:0] dvs;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic [HALF_W:0]   r_shift;
  logic [HALF_W:0]   r_sub;

  always_comb begin
    r_shift = {rem, dvd[RND_W-1]};
    r_sub   = r_shift - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(RND_W);
        dvd   <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        dvd <= {dvd[RND_W-2:0], 1'b0};
        if (r_shift >= {1'b0, dvs}) begin
          rem <= r_sub[HALF_W-1:0];
        end else begin
          rem <= r_shift[HALF_W-1:0];
        end
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/largest_gap_channel_picker.sv]
// Top level: command sequencer, bitmap gap scan and pick.
// Restart marks the new centre in the bitmap, a read then a write, and then posts its
// result; recentre and the unused command post theirs in the cycle after the transfer.
// Bisect reads the bitmap memory a word at a time and scans each word a byte per
// cycle, then picks, runs the remainder unit for wide gaps, marks each channel
// with a read and a write and posts the result.
// One command is in flight at a time. Synchronous reset clears the map
// through per-word valid bits; centre resets to half the band.
module largest_gap_channel_picker
  import lgcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [CHAN_W-1:0] centre_channel,
  input  logic [CHAN_W:0]   search_width,
  input  logic [RND_W-1:0]  random_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [CHAN_W-1:0] channel
);

  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FSC, S_BRD, S_BSC, S_PICK, S_DIV, S_MRD, S_MWR, S_FIN
  } state_t;

  state_t state;

  logic [CHAN_W-1:0] centre, lo, hi, j, i, best, start, stop, pick;
  logic              first_stage, res_found;
  logic [RND_W-1:0]  rnd;
  logic [CHAN_W-1:0] mk [3];
  logic [1:0]        mk_n, mk_k;

  ram_req_t          req;
  logic [WORD_W-1:0] rdata, wd;
  logic              rvalid;

  logic              div_start, div_done;
  logic [HALF_W-1:0] half, quarter, rem;

  logic              in_xfer, out_free, out_load;
  logic [CHAN_W-1:0] halfw, lo_new, hi_new;
  logic [CHAN_W+1:0] hi_sum;
  logic [CHAN_W-1:0] s_i, s_best, s_start, s_stop;
  logic [CHAN_W-1:0] fwd_nj, bwd_nj;

  lgcp_map_ram u_ram (
    .clk(clk), .rst(rst), .req(req), .rdata(rdata), .rvalid(rvalid)
  );

  lgcp_mod_unit u_mod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rnd), .divisor(half),
    .done(div_done), .rem(rem)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign wd       = rvalid ? rdata : '0;
  assign half     = best[CHAN_W-1:1];
  assign quarter  = {1'b0, half[HALF_W-1:1]};

  // a new result goes into the output register this cycle
  assign out_load = (in_xfer && command != CMD_RESTART && command != CMD_BISECT) ||
                    (state == S_FIN && out_free);

  always_comb begin
    halfw  = search_width[CHAN_W:1];
    lo_new = (!first_stage && centre > halfw) ? centre - halfw : '0;
    hi_sum = {2'b00, lo_new} + {1'b0, search_width};
    if (first_stage || hi_sum > (CHAN_W+2)'(NUM_CHANNELS - 1)) begin
      hi_new = CHAN_W'(NUM_CHANNELS - 1);
    end else begin
      hi_new = hi_sum[CHAN_W-1:0];
    end
  end

  always_comb begin
    req.wr_en = (state == S_MWR);
    req.clear = in_xfer && (command == CMD_RESTART);
    req.addr  = j[CHAN_W-1:BIT_W];
    req.wdata = wd | (WORD_W'(1) << mk[mk_k][BIT_W-1:0]);
    if (state == S_MRD || state == S_MWR) begin
      req.addr = mk[mk_k][CHAN_W-1:BIT_W];
    end
  end

  // walk one byte of the current word; lo and hi count as marked
  always_comb begin
    logic [CHAN_W-1:0] pos;
    logic [CHAN_W-1:0] g;
    logic              act;
    logic              hit;
    s_i     = i;
    s_best  = best;
    s_start = start;
    s_stop  = stop;
    for (int k = 0; k < 8; k++) begin
      if (state == S_BSC) begin
        pos = {j[CHAN_W-1:3], 3'(7 - k)};
        act = (pos <= j) && (pos >= lo);
        g   = s_i - pos - CHAN_W'(1);
      end else begin
        pos = {j[CHAN_W-1:3], 3'(k)};
        act = (pos >= j) && (pos <= hi);
        g   = pos - s_i - CHAN_W'(1);
      end
      hit = wd[pos[BIT_W-1:0]] || (pos == lo) || (pos == hi);
      if (act && hit) begin
        if (g > s_best) begin
          s_best = g;
          if (state == S_BSC) begin
            s_start = pos;
            s_stop  = s_i;
          end else begin
            s_start = s_i;
            s_stop  = pos;
          end
        end
        s_i = pos;
      end
    end
  end

  assign fwd_nj = {j[CHAN_W-1:3] + (CHAN_W-3)'(1), 3'b000};
  assign bwd_nj = {j[CHAN_W-1:3], 3'b000} - CHAN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      centre      <= CHAN_W'(NUM_CHANNELS / 2);
      first_stage <= 1'b1;
      out_valid   <= 1'b0;
      div_start   <= 1'b0;
      mk_k        <= '0;
      mk_n        <= '0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            res_found <= 1'b0;
            pick      <= '0;
            mk_k      <= '0;
            case (command)
              CMD_RESTART: begin
                centre <= centre_channel;
                mk[0]  <= centre_channel;
                mk_n   <= 2'd1;
                state  <= S_MRD;
              end
              CMD_RECENTRE: begin
                centre      <= centre_channel;
                first_stage <= 1'b0;
                out_valid   <= 1'b1;
                found       <= 1'b0;
                channel     <= '0;
              end
              CMD_BISECT: begin
                lo    <= lo_new;
                hi    <= hi_new;
                rnd   <= random_value;
                mk[0] <= lo_new;
                mk[1] <= hi_new;
                mk_n  <= 2'd2;
                i     <= centre;
                best  <= '0;
                start <= centre;
                stop  <= centre;
                if (centre != hi_new) begin
                  j     <= centre + CHAN_W'(1);
                  state <= S_FRD;
                end else if (centre != lo_new) begin
                  j     <= centre - CHAN_W'(1);
                  state <= S_BRD;
                end else begin
                  state <= S_PICK;
                end
              end
              default: begin
                out_valid <= 1'b1;
                found     <= 1'b0;
                channel   <= '0;
              end
            endcase
          end
        end
        S_FRD: state <= S_FSC;
        S_BRD: state <= S_BSC;
        S_FSC: begin
          best  <= s_best;
          start <= s_start;
          stop  <= s_stop;
          if ({j[CHAN_W-1:3], 3'b111} >= hi) begin
            // forward done: restart the boundary at the centre
            i <= centre;
            if (centre != lo) begin
              j     <= centre - CHAN_W'(1);
              state <= S_BRD;
            end else begin
              state <= S_PICK;
            end
          end else begin
            i <= s_i;
            j <= fwd_nj;
            if (j[BIT_W-1:3] == 2'b11) begin
              state <= S_FRD;
            end
          end
        end
        S_BSC: begin
          i     <= s_i;
          best  <= s_best;
          start <= s_start;
          stop  <= s_stop;
          if ({j[CHAN_W-1:3], 3'b000} <= lo) begin
            state <= S_PICK;
          end else begin
            j <= bwd_nj;
            if (j[BIT_W-1:3] == 2'b00) begin
              state <= S_BRD;
            end
          end
        end
        S_PICK: begin
          if (best <= CHAN_W'(GAP_MIN_LIMIT)) begin
            state <= S_MRD;
          end else if (best > CHAN_W'(GAP_WIDE_LIMIT)) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            pick      <= CHAN_W'(({1'b0, start} + {1'b0, stop}) >> 1);
            mk[2]     <= CHAN_W'(({1'b0, start} + {1'b0, stop}) >> 1);
            mk_n      <= 2'd3;
            res_found <= 1'b1;
            state     <= S_MRD;
          end
        end
        S_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            pick      <= start + CHAN_W'(rem) + CHAN_W'(quarter);
            mk[2]     <= start + CHAN_W'(rem) + CHAN_W'(quarter);
            mk_n      <= 2'd3;
            res_found <= 1'b1;
            state     <= S_MRD;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          mk_k <= mk_k + 2'd1;
          if (mk_k + 2'd1 == mk_n) begin
            state <= S_FIN;
          end else begin
            state <= S_MRD;
          end
        end
        S_FIN: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= res_found;
            channel   <= pick;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[test/tb_top.sv]
// Testbench for largest_gap_channel_picker: directed and random commands checked by a bitmap predictor.
module tb_top;
  import lgcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LAST_CHAN = NUM_CHANNELS - 1;
  localparam int N_ITEMS = 1170;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1500;

  typedef struct {
    logic [1:0]        cmd;
    logic [CHAN_W-1:0] ctr;
    logic [CHAN_W:0]   wid;
    logic [RND_W-1:0]  rnd;
    int                send_pct;
    int                stall_pct;
    bit                hold;
  } cmd_item_t;

  typedef struct {
    logic              found;
    logic [CHAN_W-1:0] channel;
  } pick_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        command = CMD_RESTART;
  logic [CHAN_W-1:0] centre_channel = '0;
  logic [CHAN_W:0]   search_width = '0;
  logic [RND_W-1:0]  random_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              found;
  logic [CHAN_W-1:0] channel;

  cmd_item_t pending_cmds[$];
  pick_t     expected_picks[$];
  bit        failed = 1'b0;
  int        idle_count = 0;
  int        cur_stall = 0;
  int        gen_send = 0;
  int        gen_stall = 0;

  // predictor state
  bit chan_probed [NUM_CHANNELS];
  int scan_centre;
  bit first_pass;

  largest_gap_channel_picker DUT (.*);

  always #4 clk = ~clk;

  task automatic push_cmd(logic [1:0] cmd, int ctr, int wid, int rnd, bit hold = 1'b0);
    cmd_item_t it;
    it.cmd = cmd;
    it.ctr = ctr[CHAN_W-1:0];
    it.wid = wid[CHAN_W:0];
    it.rnd = rnd[RND_W-1:0];
    it.send_pct = gen_send;
    it.stall_pct = gen_stall;
    it.hold = hold;
    pending_cmds.push_back(it);
  endtask

  function automatic pick_t predict_pick(cmd_item_t it);
    pick_t r;
    int lo, hi, halfw, best, start, stop, i, g, half, quarter, pk;
    r.found = 1'b0;
    r.channel = '0;
    case (it.cmd)
      CMD_RESTART: begin
        scan_centre = it.ctr;
        foreach (chan_probed[k]) chan_probed[k] = 1'b0;
        chan_probed[scan_centre] = 1'b1;
      end
      CMD_RECENTRE: begin
        scan_centre = it.ctr;
        first_pass = 1'b0;
      end
      CMD_BISECT: begin
        lo = 0;
        hi = LAST_CHAN;
        if (!first_pass) begin
          halfw = int'(it.wid) >> 1;
          lo = (scan_centre > halfw) ? scan_centre - halfw : 0;
          hi = lo + int'(it.wid);
          if (hi > LAST_CHAN) hi = LAST_CHAN;
        end
        chan_probed[lo] = 1'b1;
        chan_probed[hi] = 1'b1;
        best = 0;
        start = scan_centre;
        stop = scan_centre;
        // forward first so it keeps ties
        i = scan_centre;
        for (int j = scan_centre + 1; j <= hi; j++) begin
          if (chan_probed[j]) begin
            g = j - i - 1;
            if (g > best) begin
              best = g;
              start = i;
              stop = j;
            end
            i = j;
          end
        end
        i = scan_centre;
        for (int j = scan_centre - 1; j >= lo; j--) begin
          if (chan_probed[j]) begin
            g = i - j - 1;
            if (g > best) begin
              best = g;
              start = j;
              stop = i;
            end
            i = j;
          end
        end
        if (best > GAP_MIN_LIMIT) begin
          if (best > GAP_WIDE_LIMIT) begin
            half = best >> 1;
            quarter = half >> 1;
            pk = start + (int'(it.rnd) % half) + quarter;
          end else begin
            pk = (start + stop) >> 1;
          end
          chan_probed[pk] = 1'b1;
          r.found = 1'b1;
          r.channel = pk[CHAN_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < cur_stall);
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0
            && !(pending_cmds[0].hold && (expected_picks.size() > 0 || in_valid))
            && !($urandom_range(99) < pending_cmds[0].send_pct)) begin
          cmd_item_t it;
          it = pending_cmds.pop_front();
          cur_stall <= it.stall_pct;
          command <= it.cmd;
          centre_channel <= it.ctr;
          search_width <= it.wid;
          random_value <= it.rnd;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        cmd_item_t it;
        it.cmd = command;
        it.ctr = centre_channel;
        it.wid = search_width;
        it.rnd = random_value;
        expected_picks.push_back(predict_pick(it));
      end
      if (out_valid && !out_stall) begin
        if (expected_picks.size() == 0) begin
          $error("unexpected result transfer: found=%0d channel=%0d", found, channel);
          failed = 1'b1;
        end else begin
          pick_t e;
          e = expected_picks.pop_front();
          if (found !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, found);
            failed = 1'b1;
          end
          if (channel !== e.channel) begin
            $error("channel: expected %0d, actual %0d", e.channel, channel);
            failed = 1'b1;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_count >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("** largest_gap_channel_picker: FAILED **");
      $finish;
    end
  end

  function automatic int rand_width();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(0, 40);
    if (p < 92) return $urandom_range(0, 1024);
    return $urandom_range(0, NUM_CHANNELS);
  endfunction

  initial begin
    int n;
    int k;
    int ph;
    foreach (chan_probed[k2]) chan_probed[k2] = 1'b0;
    scan_centre = NUM_CHANNELS / 2;
    first_pass = 1'b1;

    // directed: full-band bisects from reset, band edges, narrow windows
    push_cmd(CMD_BISECT, 0, 0, 16'hFFFF);
    push_cmd(CMD_BISECT, 8191, 8192, 0);
    push_cmd(CMD_UNUSED, 8191, 16383, 16'hFFFF);
    push_cmd(CMD_RESTART, 0, 0, 0);
    push_cmd(CMD_BISECT, 0, 0, 12345);
    push_cmd(CMD_RESTART, LAST_CHAN, 0, 0);
    push_cmd(CMD_BISECT, 0, 0, 16'hFFFF);
    push_cmd(CMD_RECENTRE, 100, 0, 0);
    push_cmd(CMD_BISECT, 0, 0, 0);
    push_cmd(CMD_BISECT, 0, 1, 0);
    push_cmd(CMD_BISECT, 0, 2, 0);
    push_cmd(CMD_BISECT, 0, 4, 0);
    push_cmd(CMD_BISECT, 0, 6, 0);
    push_cmd(CMD_BISECT, 0, 6, 0);
    push_cmd(CMD_BISECT, 0, 12, 16'hFFFF);
    push_cmd(CMD_RECENTRE, 0, 0, 0);
    push_cmd(CMD_BISECT, 0, 8192, 7);
    push_cmd(CMD_RECENTRE, LAST_CHAN, 0, 0);
    push_cmd(CMD_BISECT, 0, 8192, 16'hAAAA);
    push_cmd(CMD_BISECT, 0, 16383, 16'h5555);
    push_cmd(CMD_UNUSED, 0, 0, 0);
    push_cmd(CMD_RESTART, 4000, 0, 0, 1'b1);
    push_cmd(CMD_BISECT, 0, 3, 0);
    push_cmd(CMD_BISECT, 0, 3, 0);

    n = pending_cmds.size();
    ph = 0;
    while (n < N_ITEMS) begin
      case ((n / 150) % 4)
        0: begin gen_send = 0;  gen_stall = 0;  end
        1: begin gen_send = 47; gen_stall = 0;  end
        2: begin gen_send = 0;  gen_stall = 47; end
        default: begin gen_send = 27; gen_stall = 27; end
      endcase
      if ($urandom_range(99) < 8) begin
        push_cmd(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 16383), $urandom);
        n++;
      end else begin
        k = $urandom_range(99);
        push_cmd(CMD_RESTART, (k < 5) ? 0 : (k < 10) ? LAST_CHAN : $urandom,
                 $urandom, $urandom, (ph % 25 == 24));
        ph++;
        n++;
        if ($urandom_range(99) < 85) begin
          k = $urandom_range(99);
          push_cmd(CMD_RECENTRE, (k < 5) ? 0 : (k < 10) ? LAST_CHAN : $urandom,
                   $urandom, $urandom);
          n++;
        end
        for (int b = $urandom_range(3, 20); b > 0; b--) begin
          if ($urandom_range(99) < 4) push_cmd(CMD_RECENTRE, $urandom, $urandom, $urandom);
          else push_cmd(CMD_BISECT, $urandom, rand_width(), $urandom);
          n++;
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && expected_picks.size() == 0 && !in_valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_picks.size() == 0) begin
      $display("** largest_gap_channel_picker: PASSED **");
    end else begin
      $display("** largest_gap_channel_picker: FAILED **");
    end
    $finish;
  end
endmodule
